// ----- hdl/gccc_pkg.sv -----
// shared types, constants and a helper function for the graph cycle class counter
// no dependencies
`default_nettype none

package gccc_pkg;

  localparam int MaxVertices = 16;
  localparam int RowWidth    = 16;
  localparam int SizeSlots   = 14;
  localparam int CfgWidth    = 5;

  localparam logic [0:0] RegVertexCount = 1'b0;
  localparam logic [0:0] RegMaxDepth    = 1'b1;

  localparam logic [4:0] VertexCountReset = 5'd16;
  localparam logic [4:0] MaxDepthReset    = 5'd8;

  typedef logic [MaxVertices-1:0][RowWidth-1:0] adj_t;

  typedef struct packed {
    logic [4:0] n;
    logic [4:0] md;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEGREE,
    ST_CYCLO,
    ST_ENUM,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

  function automatic logic [4:0] pop_count(input logic [RowWidth-1:0] v);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < RowWidth; i++) begin
      c = c + {4'b0, v[i]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gccc_front.sv -----
// front part: configuration registers, adjacency row storage, command issue
// depends on gccc_pkg
`default_nettype none

module gccc_front import gccc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [4:0]       cfg_data,
  input  wire logic             accept,
  input  wire logic [3:0]       row_index,
  input  wire logic [15:0]      row_bits,
  input  wire logic             last_row,
  output adj_t                  rows,
  output logic                  push,
  output cmd_t                  cmd
);

  logic [4:0] vertex_count;
  logic [4:0] depth_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VertexCountReset;
      depth_limit  <= MaxDepthReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegVertexCount: vertex_count <= cfg_data;
        RegMaxDepth:    depth_limit  <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rows[row_index] <= row_bits;
    end
  end

  assign push = accept && last_row;

  always_comb begin
    cmd.n = vertex_count;
    if (vertex_count < 5'd1) begin
      cmd.n = 5'd1;
    end else if (vertex_count > 5'(MaxVertices)) begin
      cmd.n = 5'(MaxVertices);
    end
    cmd.md = depth_limit;
    if (depth_limit < 5'd3) begin
      cmd.md = 5'd3;
    end else if (depth_limit > 5'd16) begin
      cmd.md = 5'd16;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gccc_queue.sv -----
// two-entry command queue between front and back parts
// depends on gccc_pkg
`default_nettype none

module gccc_queue import gccc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      not_empty,
  output logic      full,
  output cmd_t      head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gccc_back.sv -----
// back part: degree scan, subset enumeration and class vector output
// depends on gccc_pkg
`default_nettype none

module gccc_back import gccc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire adj_t         rows,
  input  wire logic         cmd_avail,
  input  wire cmd_t         cmd,
  output logic              pop,
  output logic              active,
  output logic              strobe,
  output logic [3:0]        entry_index,
  output logic signed [16:0] entry_value,
  output logic              last_entry
);

  back_state_t state, state_next;

  logic [4:0]  n, n_next;
  logic [4:0]  md, md_next;
  logic [4:0]  depth, depth_next;
  logic [15:0] vmask, vmask_next;
  logic [3:0]  vidx, vidx_next;
  logic [4:0]  tails, tails_next;
  logic [8:0]  degsum, degsum_next;
  logic signed [8:0] cyc, cyc_next;
  logic [15:0] subset_counter, subset_counter_next;
  logic [15:0] size_counts [SizeSlots];
  logic        hit, hit_next;
  logic [3:0]  hit_slot, hit_slot_next;
  logic [3:0]  kidx, kidx_next;
  logic        clear_counts;

  logic              strobe_next;
  logic [3:0]        entry_index_next;
  logic signed [16:0] entry_value_next;
  logic              last_entry_next;

  logic [4:0]  deg;
  logic signed [9:0] diff;
  logic [4:0]  ssize;
  logic        all_two;
  logic [15:0] inner;

  assign active = (state != ST_IDLE);

  always_comb begin
    deg  = pop_count(rows[vidx] & vmask);
    diff = $signed({1'b0, degsum}) - $signed({4'b0, n, 1'b0}) + 10'sd2;
    ssize = pop_count(subset_counter);
    all_two = 1'b1;
    for (int v = 0; v < MaxVertices; v++) begin
      inner = rows[v] & vmask & subset_counter;
      if (subset_counter[v] && (pop_count(inner) != 5'd2)) begin
        all_two = 1'b0;
      end
    end
  end

  always_comb begin
    state_next          = state;
    n_next              = n;
    md_next             = md;
    depth_next          = depth;
    vmask_next          = vmask;
    vidx_next           = vidx;
    tails_next          = tails;
    degsum_next         = degsum;
    cyc_next            = cyc;
    subset_counter_next = subset_counter;
    hit_next            = 1'b0;
    hit_slot_next       = hit_slot;
    kidx_next           = kidx;
    clear_counts        = 1'b0;
    pop                 = 1'b0;
    strobe_next         = 1'b0;
    entry_index_next    = entry_index;
    entry_value_next    = entry_value;
    last_entry_next     = last_entry;

    case (state)
      ST_IDLE: begin
        if (cmd_avail) begin
          pop                 = 1'b1;
          n_next              = cmd.n;
          md_next             = cmd.md;
          depth_next          = (cmd.md > cmd.n) ? cmd.n : cmd.md;
          for (int j = 0; j < RowWidth; j++) begin
            vmask_next[j] = (5'(j) < cmd.n);
          end
          vidx_next           = '0;
          tails_next          = '0;
          degsum_next         = '0;
          subset_counter_next = '0;
          clear_counts        = 1'b1;
          state_next          = ST_DEGREE;
        end
      end
      ST_DEGREE: begin
        degsum_next = degsum + {4'b0, deg};
        if (deg == 5'd1) begin
          tails_next = tails + 5'd1;
        end
        vidx_next = vidx + 4'd1;
        if (vidx == 4'(n - 5'd1)) begin
          state_next = ST_CYCLO;
        end
      end
      ST_CYCLO: begin
        if (diff[9] && diff[0]) begin
          cyc_next = 9'((diff + 10'sd1) >>> 1);
        end else begin
          cyc_next = 9'(diff >>> 1);
        end
        kidx_next = '0;
        if (!cyc_next[8] && (cyc_next != 9'sd0)) begin
          state_next = ST_ENUM;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_ENUM: begin
        hit_next      = all_two && (ssize >= 5'd3) && (ssize <= depth);
        hit_slot_next = 4'(ssize - 5'd3);
        if (subset_counter == vmask) begin
          state_next = ST_DRAIN;
        end else begin
          subset_counter_next = subset_counter + 16'd1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_next      = 1'b1;
        entry_index_next = kidx;
        last_entry_next  = ({1'b0, kidx} == (md - 5'd1));
        if (kidx == 4'd0) begin
          entry_value_next = {12'b0, tails};
        end else if (kidx == 4'd1) begin
          entry_value_next = {{8{cyc[8]}}, cyc};
        end else if (({1'b0, kidx} + 5'd1) <= depth) begin
          entry_value_next = {1'b0, size_counts[kidx - 4'd2]};
        end else begin
          entry_value_next = '0;
        end
        kidx_next = kidx + 4'd1;
        if (last_entry_next) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      hit            <= 1'b0;
      strobe         <= 1'b0;
      subset_counter <= '0;
    end else begin
      state          <= state_next;
      hit            <= hit_next;
      strobe         <= strobe_next;
      subset_counter <= subset_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    n           <= n_next;
    md          <= md_next;
    depth       <= depth_next;
    vmask       <= vmask_next;
    vidx        <= vidx_next;
    tails       <= tails_next;
    degsum      <= degsum_next;
    cyc         <= cyc_next;
    hit_slot    <= hit_slot_next;
    kidx        <= kidx_next;
    entry_index <= entry_index_next;
    entry_value <= entry_value_next;
    last_entry  <= last_entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst || clear_counts) begin
      for (int i = 0; i < SizeSlots; i++) begin
        size_counts[i] <= '0;
      end
    end else if (hit && (size_counts[hit_slot] != 16'hFFFF)) begin
      size_counts[hit_slot] <= size_counts[hit_slot] + 16'd1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/graph_cycle_class_counter.sv -----
// top level of the graph cycle class counter
// depends on gccc_pkg, gccc_front, gccc_queue, gccc_back
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   rows in  | start, busy             | row_index, row_bits, last_row
//   results  | strobe                  | entry_index, entry_value, last_entry
//   config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// a row without last_row leaves busy low
// a last row runs the degree scan, the cyclomatic count and the class vector output, plus subset
// enumeration (one subset per cycle in the back part) when the cyclomatic count is positive
// busy is high from the last row until the final entry has been issued
// results leave one per cycle on strobe; the receiver cannot stall
// reset is synchronous; configuration returns to 16 vertices, depth 8
`default_nettype none

module graph_cycle_class_counter import gccc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [3:0]   row_index,
  input  wire logic [15:0]  row_bits,
  input  wire logic         last_row,
  output logic              strobe,
  output logic [3:0]        entry_index,
  output logic signed [16:0] entry_value,
  output logic              last_entry,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [4:0]   cfg_data
);

  adj_t rows;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_not_empty;
  logic q_full;
  cmd_t q_head;
  logic back_active;
  logic accept;

  assign busy   = back_active || q_not_empty || q_full;
  assign accept = start && !busy;

  gccc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .row_index (row_index),
    .row_bits  (row_bits),
    .last_row  (last_row),
    .rows      (rows),
    .push      (push),
    .cmd       (push_cmd)
  );

  gccc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  gccc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rows        (rows),
    .cmd_avail   (q_not_empty),
    .cmd         (q_head),
    .pop         (pop),
    .active      (back_active),
    .strobe      (strobe),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .last_entry  (last_entry)
  );

endmodule

`default_nettype wire

// ----- test/graph_cycle_class_counter_tb.sv -----
// self-checking testbench for graph_cycle_class_counter: loads adjacency rows, predicts every
// class vector with its own model of the block and checks each entry as it leaves
// depends on gccc_pkg and the graph_cycle_class_counter rtl
`default_nettype none

module graph_cycle_class_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gccc_pkg::*;

  localparam int QuietLimit = 300000;
  localparam int SettleCycles = 16;
  localparam int RandomRowsPerPhase = 22;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] bits;
    logic        last;
  } row_item_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [16:0] value;
    logic               last;
  } class_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [3:0] row_index = '0;
  logic [15:0] row_bits = '0;
  logic last_row = 1'b0;
  logic strobe;
  logic [3:0] entry_index;
  logic signed [16:0] entry_value;
  logic last_entry;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = RegVertexCount;
  logic [4:0] cfg_data = '0;

  row_item_t pending_rows[$];
  row_item_t drive_row;
  class_entry_t entries_due[$];
  int send_gap_pct = 8;
  logic row_taken = 1'b0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int cur_vertices = 16;
  int queued_count = 0;

  // block state as the predictor sees it
  logic [15:0] model_rows [MaxVertices];
  logic [4:0] model_vertex_count = VertexCountReset;
  logic [4:0] model_depth_limit = MaxDepthReset;

  graph_cycle_class_counter uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .row_index(row_index),
    .row_bits(row_bits),
    .last_row(last_row),
    .strobe(strobe),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .last_entry(last_entry),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int ones16(input logic [15:0] v);
    int c;
    c = 0;
    for (int i = 0; i < 16; i++) c += v[i];
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_row(input row_item_t item);
    int n, md, depth, degree, degree_sum, tails, cyclo, members, value;
    logic [15:0] vmask, subset;
    logic fits;
    logic [15:0] ring_counts [17];
    class_entry_t entry;
    model_rows[item.index] = item.bits;
    if (!item.last) return;
    n = (model_vertex_count < 1) ? 1 :
        (model_vertex_count > MaxVertices) ? MaxVertices : model_vertex_count;
    md = (model_depth_limit < 3) ? 3 : (model_depth_limit > 16) ? 16 : model_depth_limit;
    depth = (md > n) ? n : md;
    vmask = '0;
    for (int v = 0; v < n; v++) vmask[v] = 1'b1;
    degree_sum = 0;
    tails = 0;
    for (int v = 0; v < n; v++) begin
      degree = ones16(model_rows[v] & vmask);
      degree_sum += degree;
      if (degree == 1) tails++;
    end
    cyclo = (degree_sum - 2 * (n - 1)) / 2;
    foreach (ring_counts[i]) ring_counts[i] = '0;
    // subsets of 3 to depth members where every member has exactly two neighbors inside
    if (cyclo > 0) begin
      for (int s = 0; s < (1 << n); s++) begin
        subset = s[15:0];
        members = ones16(subset);
        if (members < 3 || members > depth) continue;
        fits = 1'b1;
        for (int v = 0; v < n; v++) begin
          if (subset[v] && ones16(model_rows[v] & vmask & subset) != 2) fits = 1'b0;
        end
        if (fits && ring_counts[members] != 16'hFFFF) ring_counts[members]++;
      end
    end
    for (int k = 0; k < md; k++) begin
      if (k == 0) value = tails;
      else if (k == 1) value = cyclo;
      else if (k + 1 <= depth) value = ring_counts[k + 1];
      else value = 0;
      entry.index = k[3:0];
      entry.value = value[16:0];
      entry.last = (k + 1 == md);
      entries_due.push_back(entry);
    end
  endtask

  task automatic check_entry();
    class_entry_t want;
    if (entries_due.size() == 0) begin
      report_mismatch($sformatf("entry %0d arrived with nothing expected", entry_index));
      return;
    end
    want = entries_due.pop_front();
    if (entry_index !== want.index)
      report_mismatch($sformatf("entry_index %0d, expected %0d", entry_index, want.index));
    if (entry_value !== want.value)
      report_mismatch($sformatf("entry %0d entry_value %0d, expected %0d",
                                want.index, entry_value, want.value));
    if (last_entry !== want.last)
      report_mismatch($sformatf("entry %0d last_entry %0b, expected %0b",
                                want.index, last_entry, want.last));
  endtask

  // row driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || row_taken) begin
      if (pending_rows.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        drive_row = pending_rows.pop_front();
        start <= 1'b1;
        row_index <= drive_row.index;
        row_bits <= drive_row.bits;
        last_row <= drive_row.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on each accepted row, checks each entry
  always @(posedge clk) begin
    row_taken <= !rst && start && !busy;
    if (rst) begin
      model_vertex_count = VertexCountReset;
      model_depth_limit = MaxDepthReset;
    end else begin
      if (start && !busy) predict_row(row_item_t'{row_index, row_bits, last_row});
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegVertexCount) model_vertex_count = cfg_data;
        else model_depth_limit = cfg_data;
      end
      if (strobe) check_entry();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("graph_cycle_class_counter_tb NOT OK");
      $finish;
    end
  end

  task automatic queue_row(input int idx, input logic [15:0] bits, input logic last);
    pending_rows.push_back(row_item_t'{idx[3:0], bits, last});
    queued_count++;
  endtask

  task automatic drain_block();
    do @(posedge clk); while (pending_rows.size() != 0 || start || entries_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int vc, input int md);
    drain_block();
    write_reg(RegVertexCount, vc[4:0]);
    write_reg(RegMaxDepth, md[4:0]);
    cur_vertices = (vc < 1) ? 1 : (vc > MaxVertices) ? MaxVertices : vc;
  endtask

  task automatic queue_graph();
    logic [15:0] adj [16];
    logic [15:0] vmask;
    int n, kind, pct, u, w, first;
    n = cur_vertices;
    vmask = '0;
    for (int v = 0; v < n; v++) vmask[v] = 1'b1;
    foreach (adj[v]) adj[v] = '0;
    kind = $urandom_range(4);
    if (n < 3 && kind == 1) kind = 0;
    pct = (kind == 0) ? $urandom_range(20, 80) : $urandom_range(5, 30);
    case (kind)
      1: begin
        for (int v = 0; v < n; v++) begin
          w = (v + 1) % n;
          adj[v][w] = 1'b1;
          adj[w][v] = 1'b1;
        end
        repeat ($urandom_range(2)) begin
          u = $urandom_range(n - 1);
          w = $urandom_range(n - 1);
          if (u != w) begin
            adj[u][w] = 1'b1;
            adj[w][u] = 1'b1;
          end
        end
      end
      2: begin
        for (int v = 1; v < n; v++) begin
          u = $urandom_range(v - 1);
          adj[v][u] = 1'b1;
          adj[u][v] = 1'b1;
        end
      end
      3: begin
        for (int v = 0; v < n; v++) adj[v] = vmask & ~(16'd1 << v);
      end
      default: begin
        for (int v = 0; v < n; v++) begin
          for (int j = v + 1; j < n; j++) begin
            if ($urandom_range(99) < pct) begin
              adj[v][j] = 1'b1;
              adj[j][v] = 1'b1;
            end
          end
        end
      end
    endcase
    // one-sided flip: asymmetric edge or diagonal bit
    if ($urandom_range(3) == 0) begin
      u = $urandom_range(n - 1);
      w = $urandom_range(n - 1);
      adj[u][w] = ~adj[u][w];
    end
    if ($urandom_range(2) == 0) begin
      for (int v = 0; v < n; v++) adj[v] = adj[v] | (16'($urandom) & ~vmask);
    end
    repeat ($urandom_range(2)) queue_row($urandom_range(15), 16'($urandom), 1'b0);
    first = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) queue_row((first + i) % n, adj[(first + i) % n], i == n - 1);
  endtask

  initial begin
    int gap_pct [3];
    int phase_start;
    gap_pct = '{8, 65, 0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full 16-vertex load at reset settings, complete graph with a diagonal bit
    for (int v = 0; v < 16; v++) queue_row(v, (v == 0) ? 16'hFFFF : ~(16'd1 << v), v == 15);
    // single vertex, shortest vector, bits above the vertex count
    set_config(0, 0);
    queue_row(0, 16'hFFFF, 1'b1);
    // all 16 vertices, longest vector
    set_config(31, 31);
    queue_row(15, 16'h7FFF, 1'b1);
    // one triangle
    set_config(3, 3);
    queue_row(0, 16'h0006, 1'b0);
    queue_row(1, 16'h0005, 1'b0);
    queue_row(2, 16'h0003, 1'b1);
    // odd degree sum, negative cyclomatic count
    set_config(3, 4);
    queue_row(0, 16'h0002, 1'b0);
    queue_row(1, 16'h0000, 1'b0);
    queue_row(2, 16'h0000, 1'b1);
    // empty graph, depth beyond the vertex count
    set_config(4, 16);
    for (int v = 0; v < 4; v++) queue_row(v, 16'h0000, v == 3);

    for (int ph = 0; ph < 3; ph++) begin
      set_config($urandom_range(12), $urandom_range(31));
      send_gap_pct = gap_pct[ph];
      phase_start = queued_count;
      while (queued_count - phase_start < RandomRowsPerPhase) begin
        if ($urandom_range(2) == 0) set_config($urandom_range(12), $urandom_range(31));
        if ($urandom_range(3) == 0) begin
          // partial update of an already loaded graph
          repeat ($urandom_range(1))
            queue_row($urandom_range(cur_vertices - 1), 16'($urandom), 1'b0);
          queue_row($urandom_range(cur_vertices - 1), 16'($urandom), 1'b1);
        end else begin
          queue_graph();
        end
      end
    end

    drain_block();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && entries_due.size() == 0) begin
      $display("graph_cycle_class_counter_tb OK");
    end else begin
      $display("graph_cycle_class_counter_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
